// ===== hdl/rfc_pkg.sv =====
// rfc_pkg: shared types, constants and the crc byte update for the response frame checker
// no dependencies; imported by every module of the block
package rfc_pkg;

    // frame buffer size in bytes; a byte arriving on a full buffer restarts the frame
    localparam int BUFFER_BYTES = 128;

    localparam int BYTE_W        = 8;
    localparam int STATUS_W      = 3;
    localparam int FRAME_LEN_W   = 8;
    localparam int CRC_W         = 16;
    localparam int PREFIX_LEN    = 4;
    localparam int COUNT_MIN_W   = $clog2(BUFFER_BYTES + 1);
    // byte counter wide enough for the buffer depth and for the reported length
    localparam int LEN_W         = (COUNT_MIN_W > FRAME_LEN_W) ? COUNT_MIN_W : FRAME_LEN_W;
    localparam int OUT_TDATA_W   = ((STATUS_W + FRAME_LEN_W + 7) / 8) * 8;

    localparam logic [CRC_W-1:0]  CRC_POLY    = 16'h1021;
    localparam logic [BYTE_W-1:0] CHAR_CR     = 8'h0D;
    localparam logic [BYTE_W-1:0] CHAR_LF     = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_LPAREN = 8'h28;

    localparam logic [LEN_W-1:0] MIN_CRC_LEN    = LEN_W'(3);
    localparam logic [LEN_W-1:0] MIN_PREFIX_LEN = LEN_W'(7);
    localparam logic [LEN_W-1:0] ACK_FRAME_LEN  = LEN_W'(7);

    // "(NAK" and "?ACK" (first byte of the ack text is never compared)
    localparam logic [BYTE_W-1:0] NAK_TEXT [PREFIX_LEN] = '{8'h28, 8'h4E, 8'h41, 8'h4B};
    localparam logic [BYTE_W-1:0] ACK_TEXT [PREFIX_LEN] = '{8'h00, 8'h41, 8'h43, 8'h4B};

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK      = 3'd0,
        STATUS_CRC_ERR = 3'd1,
        STATUS_NAK     = 3'd2,
        STATUS_LEN_ERR = 3'd3,
        STATUS_NOT_ACK = 3'd4
    } status_t;

    // one received byte held in the input register
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } rfc_item_t;

    // crc-16 update by one byte, msb first
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < BYTE_W; i++)
        begin
            if (c[CRC_W-1])
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[CRC_W-2:0], 1'b0};
        end
        return c;
    endfunction

    // crc bytes that collide with framing characters are raised by one
    function automatic logic [BYTE_W-1:0] crc_adjust(input logic [BYTE_W-1:0] b);
        if (b == CHAR_LPAREN || b == CHAR_CR || b == CHAR_LF)
            return b + BYTE_W'(1);
        return b;
    endfunction

endpackage

// ===== hdl/rfc_in_stage.sv =====
// rfc_in_stage: input register for received bytes
// depends on rfc_pkg
module rfc_in_stage (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_axis_tvalid,
    output logic                       s_axis_tready,
    input  logic [rfc_pkg::BYTE_W-1:0] s_axis_tdata,
    input  logic                       take,
    output rfc_pkg::rfc_item_t         item
);
    import rfc_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] data_reg;

    // accept whenever the register is empty or drains this cycle
    assign s_axis_tready = !valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            valid_reg <= s_axis_tvalid;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            data_reg <= s_axis_tdata;
        end
    end

    assign item.valid = valid_reg;
    assign item.data  = data_reg;

endmodule

// ===== hdl/rfc_frame_core.sv =====
// rfc_frame_core: frame state, crc check, status decision and result register
// depends on rfc_pkg (crc_feed, crc_adjust, prefix texts, status codes)
module rfc_frame_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic                            cfg_wdata,
    input  rfc_pkg::rfc_item_t              item,
    output logic                            take,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rfc_pkg::*;

    logic                   response_kind_reg;
    logic [CRC_W-1:0]       crc_reg,    crc_next;
    logic [BYTE_W-1:0]      older_reg,  older_next;
    logic [BYTE_W-1:0]      newer_reg,  newer_next;
    logic [LEN_W-1:0]       count_reg,  count_next;
    logic                   nak_reg,    nak_next;
    logic                   ack_reg,    ack_next;
    logic                   out_valid_reg;
    status_t                status_reg, status_next;
    logic [FRAME_LEN_W-1:0] len_reg;

    logic                   overflow;
    logic [CRC_W-1:0]       crc_eff;
    logic [BYTE_W-1:0]      older_eff;
    logic [BYTE_W-1:0]      newer_eff;
    logic [LEN_W-1:0]       count_eff;
    logic                   nak_eff;
    logic                   ack_eff;
    logic                   in_prefix;
    logic                   is_cr;
    logic [LEN_W-1:0]       frame_len;
    logic                   crc_ok;
    logic                   long_enough;

    // data bytes always move on; a carriage return waits for a free or emptying result slot
    assign take  = item.valid && (!is_cr || !out_valid_reg || m_axis_tready);
    assign is_cr = (item.data == CHAR_CR);

    // full buffer restarts the frame before this byte
    always_comb
    begin
        overflow  = (count_reg >= LEN_W'(BUFFER_BYTES));
        crc_eff   = overflow ? '0 : crc_reg;
        older_eff = overflow ? '0 : older_reg;
        newer_eff = overflow ? '0 : newer_reg;
        count_eff = overflow ? '0 : count_reg;
        nak_eff   = overflow ? 1'b1 : nak_reg;
        ack_eff   = overflow ? 1'b1 : ack_reg;
    end

    // prefix tracking on the first four bytes
    always_comb
    begin
        in_prefix = (count_eff < LEN_W'(PREFIX_LEN));
        nak_next  = nak_eff;
        ack_next  = ack_eff;
        if (in_prefix && item.data != NAK_TEXT[count_eff[1:0]])
            nak_next = 1'b0;
        if (in_prefix && count_eff != '0 && item.data != ACK_TEXT[count_eff[1:0]])
            ack_next = 1'b0;
    end

    // crc compare and status for a frame ending on this byte
    always_comb
    begin
        frame_len   = count_eff + LEN_W'(1);
        long_enough = (frame_len >= MIN_PREFIX_LEN);
        crc_ok      = (frame_len >= MIN_CRC_LEN)
                      && (crc_adjust(crc_eff[CRC_W-1:BYTE_W]) == older_eff)
                      && (crc_adjust(crc_eff[BYTE_W-1:0]) == newer_eff);
        if (!response_kind_reg)
        begin
            if (!crc_ok)
                status_next = STATUS_CRC_ERR;
            else if (long_enough && nak_next)
                status_next = STATUS_NAK;
            else
                status_next = STATUS_OK;
        end
        else
        begin
            if (frame_len != ACK_FRAME_LEN)
                status_next = STATUS_LEN_ERR;
            else if (!crc_ok)
                status_next = STATUS_CRC_ERR;
            else if (ack_next)
                status_next = STATUS_OK;
            else
                status_next = STATUS_NOT_ACK;
        end
    end

    // next frame state: the two newest bytes wait out of the crc
    always_comb
    begin
        crc_next   = crc_eff;
        older_next = newer_eff;
        newer_next = item.data;
        count_next = count_eff + LEN_W'(1);
        if (count_eff >= LEN_W'(2))
            crc_next = crc_feed(crc_eff, older_eff);
    end

    // frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= '0;
            older_reg <= '0;
            newer_reg <= '0;
            count_reg <= '0;
            nak_reg   <= 1'b1;
            ack_reg   <= 1'b1;
        end
        else if (take)
        begin
            if (is_cr)
            begin
                crc_reg   <= '0;
                older_reg <= '0;
                newer_reg <= '0;
                count_reg <= '0;
                nak_reg   <= 1'b1;
                ack_reg   <= 1'b1;
            end
            else
            begin
                crc_reg   <= crc_next;
                older_reg <= older_next;
                newer_reg <= newer_next;
                count_reg <= count_next;
                nak_reg   <= nak_next;
                ack_reg   <= ack_next;
            end
        end
    end

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            response_kind_reg <= 1'b0;
        else if (cfg_wen)
            response_kind_reg <= cfg_wdata;
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (take && is_cr)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (take && is_cr)
        begin
            status_reg <= status_next;
            len_reg    <= frame_len[FRAME_LEN_W-1:0];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_TDATA_W'({len_reg, status_reg});

endmodule

// ===== hdl/response_frame_checker.sv =====
// response_frame_checker: top level of the inverter reply frame checker
// depends on rfc_pkg, rfc_in_stage, rfc_frame_core
//
// channel   direction  handshake                      payload
// s_axis    in         s_axis_tvalid/s_axis_tready    rx_byte
// m_axis    out        m_axis_tvalid/m_axis_tready    status, frame_length
// cfg       in         cfg_wen                        response_kind
//
// one byte per cycle sustained unless a carriage return waits for the result register;
// each byte is held in the input register; a taken carriage return writes the result register
// the combinational crc byte update plus prefix and crc compares set the rate
// reset clears the frame state, the mode register (poll) and both valid flags
// a stalled result holds the result register; further bytes are taken until a second
// carriage return has to wait for it
module response_frame_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic                            cfg_wdata,    // response_kind
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [rfc_pkg::BYTE_W-1:0]      s_axis_tdata, // [7:0] rx_byte
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [rfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata  // [2:0] status, [10:3] frame_length
);
    import rfc_pkg::*;

    rfc_item_t item;
    logic      take;

    rfc_in_stage u_in_stage (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .take          (take),
        .item          (item)
    );

    rfc_frame_core u_frame_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .item          (item),
        .take          (take),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== hdl/rfc_checker.sv =====
// rfc_checker: port-level assertions for response_frame_checker, bound to the top level
// depends on rfc_pkg
module rfc_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [rfc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import rfc_pkg::*;

    // stalled result stays valid and unchanged
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

    // status is one of the defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[STATUS_W-1:0] <= STATUS_NOT_ACK))
        else $error("undefined status code");

    // a frame always includes its carriage return
    a_len_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[STATUS_W+FRAME_LEN_W-1:STATUS_W] != '0))
        else $error("zero frame length");

    // nak needs the prefix ahead of the crc bytes
    a_nak_len: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[STATUS_W-1:0] == STATUS_NAK)
        |-> (m_axis_tdata[STATUS_W+FRAME_LEN_W-1:STATUS_W] >= FRAME_LEN_W'(7)))
        else $error("nak reported on a short frame");

endmodule

bind response_frame_checker rfc_checker u_rfc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== verif/response_frame_checker_test.sv =====
// response_frame_checker_test: self-checking bench for the inverter reply frame checker
// drives byte streams in poll and command mode and checks every frame report against a
// built-in predictor; depends on rfc_pkg and response_frame_checker
module response_frame_checker_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rfc_pkg::*;

    typedef logic [BYTE_W-1:0] byte_q_t[$];

    typedef struct packed {
        status_t                status;
        logic [FRAME_LEN_W-1:0] length;
    } frame_report_t;

    // frame status predictor plus the reports it still waits for
    class frame_status_predictor;
        logic [CRC_W-1:0]   crc_acc;
        logic [BYTE_W-1:0]  held_older;
        logic [BYTE_W-1:0]  held_newer;
        int unsigned        bytes_in_frame;
        bit                 nak_match;
        bit                 ack_match;
        bit                 ack_mode;
        frame_report_t      pending_reports[$];
        int                 errors;
        int                 reports_checked;
        int                 status_seen[5];
        int                 frames_by_mode[2];

        function new();
            ack_mode = 1'b0;
            errors = 0;
            reports_checked = 0;
            foreach (status_seen[i])
                status_seen[i] = 0;
            frames_by_mode[0] = 0;
            frames_by_mode[1] = 0;
            restart_frame();
        endfunction

        // crc-16 ccitt, one data bit at a time, msb first
        static function logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                   input logic [BYTE_W-1:0] b);
            logic [CRC_W-1:0] r;
            logic             fb;
            r = crc;
            for (int i = BYTE_W - 1; i >= 0; i--)
            begin
                fb = r[CRC_W-1] ^ b[i];
                r = {r[CRC_W-2:0], 1'b0} ^ (fb ? CRC_POLY : '0);
            end
            return r;
        endfunction

        // crc bytes that look like framing characters go up by one
        static function logic [BYTE_W-1:0] bump(input logic [BYTE_W-1:0] b);
            logic [BYTE_W-1:0] r;
            r = b;
            if (b == CHAR_LPAREN || b == CHAR_CR || b == CHAR_LF)
                r = b + 8'd1;
            return r;
        endfunction

        function void restart_frame();
            crc_acc = '0;
            held_older = '0;
            held_newer = '0;
            bytes_in_frame = 0;
            nak_match = 1'b1;
            ack_match = 1'b1;
        endfunction

        function void set_mode(input bit v);
            ack_mode = v;
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        // one accepted input transfer
        function void take_byte(input logic [BYTE_W-1:0] b);
            int unsigned   len;
            bit            crc_good;
            frame_report_t rep;
            if (bytes_in_frame >= BUFFER_BYTES)
                restart_frame();
            // prefix tracking over bytes 0..3
            if (bytes_in_frame < PREFIX_LEN)
            begin
                if (b != NAK_TEXT[bytes_in_frame])
                    nak_match = 1'b0;
                if (bytes_in_frame != 0 && b != ACK_TEXT[bytes_in_frame])
                    ack_match = 1'b0;
            end
            if (b != CHAR_CR)
            begin
                if (bytes_in_frame >= 2)
                    crc_acc = crc_step(crc_acc, held_older);
                held_older = held_newer;
                held_newer = b;
                bytes_in_frame++;
                return;
            end
            // carriage return closes the frame
            len = bytes_in_frame + 1;
            if (len < 3)
                crc_good = 1'b0;
            else
                crc_good = (bump(crc_acc[15:8]) == held_older) &&
                           (bump(crc_acc[7:0]) == held_newer);
            if (!ack_mode)
            begin
                if (!crc_good)
                    rep.status = STATUS_CRC_ERR;
                else if (len >= 7 && nak_match)
                    rep.status = STATUS_NAK;
                else
                    rep.status = STATUS_OK;
            end
            else
            begin
                if (len != 7)
                    rep.status = STATUS_LEN_ERR;
                else if (!crc_good)
                    rep.status = STATUS_CRC_ERR;
                else if (ack_match)
                    rep.status = STATUS_OK;
                else
                    rep.status = STATUS_NOT_ACK;
            end
            rep.length = len[FRAME_LEN_W-1:0];
            pending_reports.push_back(rep);
            frames_by_mode[ack_mode]++;
            restart_frame();
        endfunction

        // one accepted output transfer
        function void check_report(input logic [OUT_TDATA_W-1:0] tdata);
            frame_report_t          want;
            logic [STATUS_W-1:0]    got_status;
            logic [FRAME_LEN_W-1:0] got_len;
            got_status = tdata[STATUS_W-1:0];
            got_len = tdata[STATUS_W +: FRAME_LEN_W];
            if (pending_reports.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: report with none pending: status %0d length %0d",
                             got_status, got_len);
                return;
            end
            want = pending_reports.pop_front();
            reports_checked++;
            if (got_status < 5)
                status_seen[got_status]++;
            if (got_status !== want.status || got_len !== want.length)
            begin
                errors++;
                if (errors <= 10)
                    $display("ERROR: report %0d: expected status %0d length %0d, got status %0d length %0d",
                             reports_checked, want.status, want.length, got_status, got_len);
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n = 1'b0;
    logic                   cfg_wen = 1'b0;
    logic                   cfg_wdata = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [BYTE_W-1:0]      s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    frame_status_predictor sb = new();
    bit gaps_on = 1'b1;
    bit hold_request = 1'b0;
    int bytes_sent = 0;
    int overflows = 0;

    response_frame_checker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wen       (cfg_wen),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // receiver: random stall bursts and the long hold-off, counted here
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left = 80;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(1, 5) - 1;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // output monitor
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
            sb.check_report(m_axis_tdata);
    end

    // random byte that never ends a frame
    function automatic logic [BYTE_W-1:0] data_byte();
        logic [BYTE_W-1:0] v;
        v = BYTE_W'($urandom_range(0, 255));
        if (v == CHAR_CR)
            v = ~v;
        return v;
    endfunction

    function automatic logic [CRC_W-1:0] crc_over(input byte_q_t q);
        logic [CRC_W-1:0] c;
        c = '0;
        foreach (q[i])
            c = frame_status_predictor::crc_step(c, q[i]);
        return c;
    endfunction

    // one input transfer, with an optional gap in front
    task automatic push_byte(input logic [BYTE_W-1:0] b);
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= b;
        do
            @(posedge clk);
        while (s_axis_tready !== 1'b1);
        sb.take_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    // body, optional checksum (good or spoiled), then the carriage return
    task automatic send_frame(input byte_q_t body, input bit add_crc, input bit spoil);
        logic [CRC_W-1:0]  c;
        logic [BYTE_W-1:0] hi;
        logic [BYTE_W-1:0] lo;
        c = crc_over(body);
        foreach (body[i])
            push_byte(body[i]);
        if (add_crc)
        begin
            hi = frame_status_predictor::bump(c[15:8]);
            lo = frame_status_predictor::bump(c[7:0]);
            if (spoil)
                lo = lo ^ 8'h01;
            push_byte(hi);
            push_byte(lo);
        end
        push_byte(CHAR_CR);
    endtask

    // let every report come out, then let the pipeline idle
    task automatic drain_and_pause();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (6) @(negedge clk);
    endtask

    task automatic write_kind(input bit v);
        cfg_wen <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_wen <= 1'b0;
        sb.set_mode(v);
        @(negedge clk);
    endtask

    // mostly well-formed frames, some broken ones and some noise
    task automatic send_random_frame();
        byte_q_t body;
        int      pick;
        int      n;
        int      spot;
        body = {};
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            body.push_back(CHAR_LPAREN);
            n = $urandom_range(0, 16);
            repeat (n) body.push_back(data_byte());
            send_frame(body, 1'b1, 1'b0);
        end
        else if (pick < 37)
        begin
            foreach (NAK_TEXT[i])
                body.push_back(NAK_TEXT[i]);
            n = $urandom_range(0, 4);
            repeat (n) body.push_back(data_byte());
            send_frame(body, 1'b1, 1'b0);
        end
        else if (pick < 55)
        begin
            body.push_back(data_byte());
            for (int i = 1; i < PREFIX_LEN; i++)
                body.push_back(ACK_TEXT[i]);
            send_frame(body, 1'b1, 1'b0);
        end
        else if (pick < 63)
        begin
            // mixed nak and ack prefix with one byte replaced at random
            foreach (NAK_TEXT[i])
                body.push_back($urandom_range(0, 1) ? NAK_TEXT[i] : ACK_TEXT[i]);
            spot = $urandom_range(0, PREFIX_LEN - 1);
            body[spot] = data_byte();
            send_frame(body, 1'b1, 1'b0);
        end
        else if (pick < 73)
        begin
            body.push_back(CHAR_LPAREN);
            n = $urandom_range(0, 9);
            repeat (n) body.push_back(data_byte());
            send_frame(body, 1'b1, 1'b1);
        end
        else if (pick < 85)
        begin
            n = $urandom_range(0, 5);
            repeat (n) body.push_back(data_byte());
            send_frame(body, 1'b0, 1'b0);
        end
        else if (pick < 96)
        begin
            // raw noise, carriage returns included
            n = $urandom_range(1, 12);
            repeat (n) body.push_back(BYTE_W'($urandom_range(0, 255)));
            send_frame(body, 1'b0, 1'b0);
        end
        else
        begin
            n = $urandom_range(2, 6);
            repeat (n) body.push_back(data_byte());
            send_frame(body, 1'b1, 1'b0);
        end
    endtask

    task automatic random_frames(input int budget);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < budget)
            send_random_frame();
    endtask

    // main sequence
    initial
    begin
        byte_q_t body;
        byte_q_t none;
        int      waited;
        logic [CRC_W-1:0] c;
        none = {};

        // reset
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // poll mode after reset: short frames, empty body, nak, prefix in checksum
        send_frame(none, 1'b0, 1'b0);
        body = {8'hFF};
        send_frame(body, 1'b0, 1'b0);
        send_frame(none, 1'b1, 1'b0);
        body = {NAK_TEXT[0], NAK_TEXT[1], NAK_TEXT[2], NAK_TEXT[3]};
        send_frame(body, 1'b1, 1'b0);
        body = {NAK_TEXT[0], NAK_TEXT[1], NAK_TEXT[2]};
        send_frame(body, 1'b1, 1'b0);
        // checksum byte that needs the framing bump
        for (int tries = 0; tries < 4000; tries++)
        begin
            body = {CHAR_LPAREN, data_byte(), data_byte(), data_byte()};
            c = crc_over(body);
            if (frame_status_predictor::bump(c[15:8]) != c[15:8] ||
                frame_status_predictor::bump(c[7:0]) != c[7:0])
                break;
        end
        send_frame(body, 1'b1, 1'b0);
        body = {CHAR_LPAREN, 8'hFF, 8'h00};
        send_frame(body, 1'b1, 1'b1);
        drain_and_pause();

        // command mode: ack, ack with odd first byte, nak, bad checksum, wrong lengths
        write_kind(1'b1);
        body = {CHAR_LPAREN, ACK_TEXT[1], ACK_TEXT[2], ACK_TEXT[3]};
        send_frame(body, 1'b1, 1'b0);
        send_frame(body, 1'b1, 1'b1);
        body[0] = 8'hFF;
        send_frame(body, 1'b1, 1'b0);
        body = {NAK_TEXT[0], NAK_TEXT[1], NAK_TEXT[2], NAK_TEXT[3]};
        send_frame(body, 1'b1, 1'b0);
        body = {CHAR_LPAREN, ACK_TEXT[1], ACK_TEXT[2]};
        send_frame(body, 1'b1, 1'b0);
        send_frame(none, 1'b0, 1'b0);
        drain_and_pause();

        // random poll traffic
        write_kind(1'b0);
        random_frames(30);
        drain_and_pause();

        // random command traffic with a long receiver hold-off in the middle
        write_kind(1'b1);
        random_frames(20);
        hold_request = 1'b1;
        repeat (8) send_frame(none, 1'b0, 1'b0);
        random_frames(20);
        drain_and_pause();

        // poll mode: longest frame, then a buffer overflow ahead of a random frame
        write_kind(1'b0);
        body = {CHAR_LPAREN};
        repeat (BUFFER_BYTES - 4) body.push_back(data_byte());
        send_frame(body, 1'b1, 1'b0);
        repeat (1)
        begin
            repeat (BUFFER_BYTES + $urandom_range(0, 6)) push_byte(data_byte());
            overflows++;
            send_random_frame();
        end
        random_frames(10);

        // last stretch without idling on either side
        gaps_on = 1'b0;
        random_frames(30);

        // wind down
        s_axis_tvalid <= 1'b0;
        waited = 0;
        while (sb.pending() != 0 && waited < 2000)
        begin
            @(negedge clk);
            waited++;
        end
        repeat (10) @(negedge clk);
        if (sb.pending() != 0)
        begin
            $display("ERROR: %0d frame reports never arrived", sb.pending());
            sb.errors += sb.pending();
        end

        $display("sent %0d bytes: %0d poll and %0d command frames, %0d buffer overflows",
                 bytes_sent, sb.frames_by_mode[0], sb.frames_by_mode[1], overflows);
        $display("checked %0d reports: ok %0d, crc %0d, nak %0d, length %0d, not-ack %0d",
                 sb.reports_checked, sb.status_seen[0], sb.status_seen[1],
                 sb.status_seen[2], sb.status_seen[3], sb.status_seen[4]);
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
